[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/rrs_pkg.sv]
// Types and constants for the round-robin schedule simulator.
`default_nettype none
package rrs_pkg;
  localparam int FIELD_W    = 16;  // arrival/burst port width
  localparam int QUANT_W    = 16;  // time quantum register width
  localparam int OUT_W      = 21;  // result time fields
  localparam int IDX_OUT_W  = 4;   // result job index
  localparam int RESULT_CAP = 16;  // results per set at most

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SW_RD,
    ST_SW_EX,
    ST_OUT_RD,
    ST_OUT_EX
  } state_t;
endpackage
`default_nettype wire

[rtl/rrs_ifs.sv]
// Valid/ready channel interfaces for job requests and results.
`default_nettype none
interface rrs_job_if;
  logic                        valid;
  logic                        ready;
  logic [rrs_pkg::FIELD_W-1:0] arrival_time;
  logic [rrs_pkg::FIELD_W-1:0] burst_time;
  logic                        last_job;

  modport source(output valid, arrival_time, burst_time, last_job, input ready);
  modport sink(input valid, arrival_time, burst_time, last_job, output ready);
endinterface

interface rrs_result_if;
  logic                          valid;
  logic                          ready;
  logic [rrs_pkg::IDX_OUT_W-1:0] job_index;
  logic [rrs_pkg::OUT_W-1:0]     completion_time;
  logic [rrs_pkg::OUT_W-1:0]     turnaround_time;
  logic [rrs_pkg::OUT_W-1:0]     waiting_time;
  logic                          last_result;

  modport source(output valid, job_index, completion_time, turnaround_time,
                 waiting_time, last_result, input ready);
  modport sink(input valid, job_index, completion_time, turnaround_time,
               waiting_time, last_result, output ready);
endinterface
`default_nettype wire

[rtl/round_robin_schedule_sim_unit.sv]
// Round-robin scheduling simulator: job store, sweep engine and result stage.
`default_nettype none
`include "assert_macros.svh"
// Job requests load at one per cycle into two single-port job memories
// (arrival/burst and remaining/completion). The request with last_job set
// stops input and starts the simulation: each visit of a job in a sweep is a
// synchronous read, then update and write-back; a sweep that finds no ready
// job jumps the clock straight to the earliest pending arrival. Results then
// leave in load order (read, then compute into the output register), held
// while the sink stalls. Input is ready again when the last result of the
// set is loaded into the output register; jobs beyond MAX_PROCESSES are
// dropped, and at most sixteen results are returned per set. A time quantum of
// zero acts as one.
module round_robin_schedule_sim_unit #(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_BITS     = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rrs_pkg::QUANT_W-1:0]  cfg_wr_data,
  rrs_job_if.sink                           job,
  rrs_result_if.source                      result
);

  localparam int IW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW   = $clog2(MAX_PROCESSES + 1);
  localparam int CLK  = TIME_BITS + $clog2(MAX_PROCESSES + 1);
  localparam int RW   = (TIME_BITS > rrs_pkg::QUANT_W) ? TIME_BITS : rrs_pkg::QUANT_W;
  localparam int WIDE = (CLK > rrs_pkg::OUT_W) ? CLK : rrs_pkg::OUT_W;
  localparam int AW   = 2 * TIME_BITS;
  localparam int BW   = TIME_BITS + CLK;

  rrs_pkg::state_t state, state_next;

  logic [rrs_pkg::QUANT_W-1:0] time_quantum;
  logic [CW-1:0]               job_count;
  logic [CW-1:0]               done_count;
  logic [CLK-1:0]              sim_clock;
  logic [IW-1:0]               idx;
  logic                        found;
  logic [TIME_BITS-1:0]        min_arr;

  // job memories
  logic [AW-1:0] mem_a [MAX_PROCESSES];
  logic [BW-1:0] mem_b [MAX_PROCESSES];
  logic [AW-1:0] a_rd;
  logic [BW-1:0] b_rd;
  logic          rd_en;
  logic          a_we;
  logic          b_we;
  logic [IW-1:0] wr_addr;
  logic [BW-1:0] b_wd;

  // control strobes
  logic load_fire;
  logic store_we;
  logic res_load;

  // load path
  logic [TIME_BITS-1:0] arr_in;
  logic [TIME_BITS-1:0] bur_in;
  logic [CW-1:0]        count_ld;
  logic [CW-1:0]        done_ld;

  // sweep path
  logic [TIME_BITS-1:0]        rd_arr;
  logic [TIME_BITS-1:0]        rd_bur;
  logic [TIME_BITS-1:0]        rd_rem;
  logic [CLK-1:0]              rd_comp;
  logic [rrs_pkg::QUANT_W-1:0] q_eff;
  logic                        pend;
  logic                        run_now;
  logic [RW-1:0]               run_len;
  logic [TIME_BITS-1:0]        rem_new;
  logic [CLK-1:0]              clock_sw;
  logic [CW-1:0]               done_sw;
  logic [TIME_BITS-1:0]        min_next;
  logic                        found_any;
  logic                        sweep_last;

  // result path
  logic                 out_last;
  logic [CLK-1:0]       ct_clk;
  logic [CLK-1:0]       tat_clk;
  logic [CLK-1:0]       wt_clk;
  logic [WIDE-1:0]      ct_w;
  logic [WIDE-1:0]      tat_w;
  logic [WIDE-1:0]      wt_w;

  logic                               res_valid;
  logic [rrs_pkg::IDX_OUT_W-1:0]      res_idx;
  logic [rrs_pkg::OUT_W-1:0]          res_ct;
  logic [rrs_pkg::OUT_W-1:0]          res_tat;
  logic [rrs_pkg::OUT_W-1:0]          res_wt;
  logic                               res_last;

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[wr_addr] <= {arr_in, bur_in};
    end
    if (b_we) begin
      mem_b[wr_addr] <= b_wd;
    end
    if (rd_en) begin
      a_rd <= mem_a[idx];
      b_rd <= mem_b[idx];
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    arr_in   = TIME_BITS'(job.arrival_time);
    bur_in   = TIME_BITS'(job.burst_time);
    count_ld = store_we ? job_count + CW'(1) : job_count;
    done_ld  = (store_we && bur_in == '0) ? done_count + CW'(1) : done_count;

    rd_arr  = a_rd[AW-1:TIME_BITS];
    rd_bur  = a_rd[TIME_BITS-1:0];
    rd_rem  = b_rd[BW-1:CLK];
    rd_comp = b_rd[CLK-1:0];

    q_eff   = (time_quantum == '0) ? rrs_pkg::QUANT_W'(1) : time_quantum;
    pend    = (rd_rem != '0);
    run_now = pend && (CLK'(rd_arr) <= sim_clock);
    run_len = (RW'(rd_rem) > RW'(q_eff)) ? RW'(q_eff) : RW'(rd_rem);
    rem_new = TIME_BITS'(RW'(rd_rem) - run_len);
    clock_sw = run_now ? sim_clock + CLK'(run_len) : sim_clock;
    done_sw  = (run_now && rem_new == '0) ? done_count + CW'(1) : done_count;
    min_next = (pend && rd_arr < min_arr) ? rd_arr : min_arr;
    found_any  = found || run_now;
    sweep_last = (32'(idx) == 32'(job_count) - 1);

    out_last = (32'(idx) == 32'(job_count) - 1) || (32'(idx) == rrs_pkg::RESULT_CAP - 1);
    // a zero burst finishes on arrival and never touches the completion entry
    ct_clk  = (rd_bur == '0) ? CLK'(rd_arr) : rd_comp;
    tat_clk = (rd_bur == '0) ? '0 : ct_clk - CLK'(rd_arr);
    wt_clk  = tat_clk - CLK'(rd_bur);
    ct_w    = WIDE'(ct_clk);
    tat_w   = WIDE'(tat_clk);
    wt_w    = WIDE'(wt_clk);
  end

  // ---------------- control outputs ----------------
  always_comb begin
    job.ready = (state == rrs_pkg::ST_LOAD);
    load_fire = job.valid && (state == rrs_pkg::ST_LOAD);
    store_we  = load_fire && (job_count != CW'(MAX_PROCESSES));
    rd_en     = (state == rrs_pkg::ST_SW_RD) || (state == rrs_pkg::ST_OUT_RD);
    res_load  = (state == rrs_pkg::ST_OUT_EX) && (!res_valid || result.ready);
    a_we      = store_we;
    b_we      = store_we || ((state == rrs_pkg::ST_SW_EX) && run_now);
    wr_addr   = (state == rrs_pkg::ST_LOAD) ? job_count[IW-1:0] : idx;
    b_wd      = (state == rrs_pkg::ST_LOAD) ? {bur_in, CLK'(0)} : {rem_new, clock_sw};
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      rrs_pkg::ST_LOAD: begin
        if (load_fire && job.last_job) begin
          state_next = (done_ld == count_ld) ? rrs_pkg::ST_OUT_RD : rrs_pkg::ST_SW_RD;
        end
      end
      rrs_pkg::ST_SW_RD: begin
        state_next = rrs_pkg::ST_SW_EX;
      end
      rrs_pkg::ST_SW_EX: begin
        if (sweep_last && done_sw == job_count) begin
          state_next = rrs_pkg::ST_OUT_RD;
        end else begin
          state_next = rrs_pkg::ST_SW_RD;
        end
      end
      rrs_pkg::ST_OUT_RD: begin
        state_next = rrs_pkg::ST_OUT_EX;
      end
      rrs_pkg::ST_OUT_EX: begin
        if (res_load) begin
          state_next = out_last ? rrs_pkg::ST_LOAD : rrs_pkg::ST_OUT_RD;
        end
      end
      default: begin
        state_next = rrs_pkg::ST_LOAD;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rrs_pkg::ST_LOAD;
      time_quantum <= rrs_pkg::QUANTUM_RESET;
      job_count    <= '0;
      done_count   <= '0;
      sim_clock    <= '0;
      idx          <= '0;
      found        <= 1'b0;
      min_arr      <= '1;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        time_quantum <= cfg_wr_data;
      end
      if (load_fire) begin
        job_count <= count_ld;
        done_count <= done_ld;
        idx       <= '0;
        found     <= 1'b0;
        min_arr   <= '1;
      end
      if (state == rrs_pkg::ST_SW_EX) begin
        done_count <= done_sw;
        // idle sweep: every pending job arrives later, skip to the earliest
        if (sweep_last && !found_any && done_sw != job_count) begin
          sim_clock <= CLK'(min_next);
        end else begin
          sim_clock <= clock_sw;
        end
        if (sweep_last) begin
          idx     <= '0;
          found   <= 1'b0;
          min_arr <= '1;
        end else begin
          idx     <= idx + IW'(1);
          found   <= found_any;
          min_arr <= min_next;
        end
      end
      if (res_load) begin
        if (out_last) begin
          job_count  <= '0;
          done_count <= '0;
          sim_clock  <= '0;
          idx        <= '0;
        end else begin
          idx <= idx + IW'(1);
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_idx  <= rrs_pkg::IDX_OUT_W'(idx);
      res_ct   <= ct_w[rrs_pkg::OUT_W-1:0];
      res_tat  <= tat_w[rrs_pkg::OUT_W-1:0];
      res_wt   <= wt_w[rrs_pkg::OUT_W-1:0];
      res_last <= out_last;
    end
  end

  assign result.valid           = res_valid;
  assign result.job_index       = res_idx;
  assign result.completion_time = res_ct;
  assign result.turnaround_time = res_tat;
  assign result.waiting_time    = res_wt;
  assign result.last_result     = res_last;

  // ---------------- assertions ----------------
  `ASSERT_ALWAYS(a_done_le_count, clk, rst, done_count <= job_count)
  `ASSERT_ALWAYS(a_sim_has_jobs, clk, rst, (state == rrs_pkg::ST_LOAD) || (job_count != '0))
  `ASSERT_NEXT(a_clock_monotonic, clk, rst, state == rrs_pkg::ST_SW_EX, sim_clock >= $past(sim_clock))

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for the round-robin schedule simulator: job requests in, per-job results checked.
`timescale 1ns / 100ps

module tb;

  localparam int JOB_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_JOBS  = 14;

  typedef struct packed {
    logic [rrs_pkg::IDX_OUT_W-1:0] job_index;
    logic [rrs_pkg::OUT_W-1:0]     completion_time;
    logic [rrs_pkg::OUT_W-1:0]     turnaround_time;
    logic [rrs_pkg::OUT_W-1:0]     waiting_time;
    logic                          last_result;
  } sched_result_t;

  typedef struct packed {
    logic [rrs_pkg::FIELD_W-1:0] arrival;
    logic [rrs_pkg::FIELD_W-1:0] burst;
    logic                        last;
    logic                        pinned;
    sched_result_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [rrs_pkg::QUANT_W-1:0] cfg_wr_data;

  rrs_job_if    job_ch ();
  rrs_result_if result_ch ();

  round_robin_schedule_sim_unit #(
    .MAX_PROCESSES(JOB_SLOTS),
    .TIME_BITS    (rrs_pkg::FIELD_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .job        (job_ch),
    .result     (result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // jobs held for the set being loaded, plus the quantum the block runs with
  logic [rrs_pkg::FIELD_W-1:0] set_arrival [JOB_SLOTS];
  logic [rrs_pkg::FIELD_W-1:0] set_burst   [JOB_SLOTS];
  logic                        set_pinned  [JOB_SLOTS];
  sched_result_t               set_pinned_result [JOB_SLOTS];
  int                          set_jobs = 0;
  logic [rrs_pkg::QUANT_W-1:0] quantum_copy = rrs_pkg::QUANTUM_RESET;

  sched_result_t due_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  // Directed sets, loaded with the reset quantum of 2.
  stim_row_t directed_rows [25] = '{
    // single job, two turns
    '{16'd0,     16'd3,     1'b1, 1'b1, '{4'd0, 21'd3,      21'd3,     21'd0, 1'b1}},
    // zero burst at the latest arrival
    '{16'hFFFF,  16'd0,     1'b1, 1'b1, '{4'd0, 21'd65535,  21'd0,     21'd0, 1'b1}},
    // longest job at the latest arrival: idle jump, then 32768 turns
    '{16'hFFFF,  16'hFFFF,  1'b1, 1'b1, '{4'd0, 21'd131070, 21'd65535, 21'd0, 1'b1}},
    // mixed set with a zero burst and an idle gap
    '{16'd0,     16'd5,     1'b0, 1'b0, '0},
    '{16'd1,     16'd3,     1'b0, 1'b0, '0},
    '{16'd2,     16'd0,     1'b0, 1'b0, '0},
    '{16'd20,    16'd4,     1'b0, 1'b0, '0},
    '{16'd3,     16'd1,     1'b1, 1'b0, '0},
    // full store: the seventeenth request is dropped but still starts the run
    '{16'd0,     16'd1,     1'b0, 1'b0, '0},
    '{16'd1,     16'd2,     1'b0, 1'b0, '0},
    '{16'd2,     16'd0,     1'b0, 1'b0, '0},
    '{16'd3,     16'd3,     1'b0, 1'b0, '0},
    '{16'd4,     16'd1,     1'b0, 1'b0, '0},
    '{16'd5,     16'd5,     1'b0, 1'b0, '0},
    '{16'd6,     16'd2,     1'b0, 1'b0, '0},
    '{16'd7,     16'd4,     1'b0, 1'b0, '0},
    '{16'd8,     16'd1,     1'b0, 1'b0, '0},
    '{16'd9,     16'd6,     1'b0, 1'b0, '0},
    '{16'd10,    16'd2,     1'b0, 1'b0, '0},
    '{16'd11,    16'd0,     1'b0, 1'b0, '0},
    '{16'd12,    16'd3,     1'b0, 1'b0, '0},
    '{16'd13,    16'd1,     1'b0, 1'b0, '0},
    '{16'hFFFF,  16'd2,     1'b0, 1'b0, '0},
    '{16'd15,    16'd7,     1'b0, 1'b0, '0},
    '{16'd16,    16'd9,     1'b1, 1'b0, '0}
  };

  // Round-robin sweep over the held set; queues one result per job.
  function automatic void run_round_robin();
    longint remaining [JOB_SLOTS];
    longint finish_at [JOB_SLOTS];
    longint clock_now;
    longint slice;
    longint next_arrival;
    longint q;
    longint turnaround;
    int done;
    bit found;
    sched_result_t res;
    q = (quantum_copy == '0) ? 1 : longint'(quantum_copy);
    clock_now = 0;
    done = 0;
    for (int i = 0; i < set_jobs; i++) begin
      remaining[i] = longint'(set_burst[i]);
      if (remaining[i] == 0) begin
        finish_at[i] = longint'(set_arrival[i]);
        done++;
      end
    end
    while (done < set_jobs) begin
      found = 1'b0;
      for (int i = 0; i < set_jobs; i++) begin
        if (longint'(set_arrival[i]) <= clock_now && remaining[i] > 0) begin
          found = 1'b1;
          slice = (remaining[i] > q) ? q : remaining[i];
          clock_now += slice;
          remaining[i] -= slice;
          if (remaining[i] == 0) begin
            finish_at[i] = clock_now;
            done++;
          end
        end
      end
      if (!found) begin
        next_arrival = 64'sh7FFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < set_jobs; i++)
          if (remaining[i] > 0 && longint'(set_arrival[i]) < next_arrival)
            next_arrival = longint'(set_arrival[i]);
        clock_now = (next_arrival > clock_now) ? next_arrival : clock_now + 1;
      end
    end
    for (int i = 0; i < set_jobs; i++) begin
      if (set_pinned[i]) begin
        due_results.push_back(set_pinned_result[i]);
      end else begin
        turnaround          = finish_at[i] - longint'(set_arrival[i]);
        res.job_index       = rrs_pkg::IDX_OUT_W'(i);
        res.completion_time = rrs_pkg::OUT_W'(finish_at[i]);
        res.turnaround_time = (set_burst[i] == '0) ? '0 : rrs_pkg::OUT_W'(turnaround);
        res.waiting_time    = (set_burst[i] == '0) ? '0 :
                              rrs_pkg::OUT_W'(turnaround - longint'(set_burst[i]));
        res.last_result     = (i == set_jobs - 1);
        due_results.push_back(res);
      end
    end
    set_jobs = 0;
  endfunction

  task automatic send_job(input logic [rrs_pkg::FIELD_W-1:0] arrival,
                          input logic [rrs_pkg::FIELD_W-1:0] burst,
                          input logic last, input logic pinned, input sched_result_t want);
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      9:             gap = $urandom_range(8, 40);
      default:       gap = $urandom_range(1, 3);
    endcase
    if (gap > 0) begin
      job_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    job_ch.valid        <= 1'b1;
    job_ch.arrival_time <= arrival;
    job_ch.burst_time   <= burst;
    job_ch.last_job     <= last;
    @(posedge clk);
    while (!job_ch.ready) @(posedge clk);
    if (set_jobs < JOB_SLOTS) begin
      set_arrival[set_jobs]       = arrival;
      set_burst[set_jobs]         = burst;
      set_pinned[set_jobs]        = pinned;
      set_pinned_result[set_jobs] = want;
      set_jobs++;
    end
    if (last) begin
      run_round_robin();
      // block is busy simulating; drop valid so nothing stale is taken later
      job_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_quantum(input logic [rrs_pkg::QUANT_W-1:0] value);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    quantum_copy = value;
  endtask

  // result sink: open windows of random length, short stalls, now and then a long one
  initial begin
    int open_len;
    int stall_len;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      open_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 8);
      stall_len = ($urandom_range(0, 9) == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      result_ch.ready <= 1'b1;
      repeat (open_len) @(posedge clk);
      result_ch.ready <= 1'b0;
      repeat (stall_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result for job_index %0d", result_ch.job_index);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        if (result_ch.job_index !== want.job_index) begin
          $error("job_index: expected %0d, got %0d", want.job_index, result_ch.job_index);
          mismatch_count++;
        end
        if (result_ch.completion_time !== want.completion_time) begin
          $error("completion_time: expected %0d, got %0d",
                 want.completion_time, result_ch.completion_time);
          mismatch_count++;
        end
        if (result_ch.turnaround_time !== want.turnaround_time) begin
          $error("turnaround_time: expected %0d, got %0d",
                 want.turnaround_time, result_ch.turnaround_time);
          mismatch_count++;
        end
        if (result_ch.waiting_time !== want.waiting_time) begin
          $error("waiting_time: expected %0d, got %0d",
                 want.waiting_time, result_ch.waiting_time);
          mismatch_count++;
        end
        if (result_ch.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, result_ch.last_result);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("round_robin_schedule_sim_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [rrs_pkg::QUANT_W-1:0] quantum_plan [6];
    logic [rrs_pkg::FIELD_W-1:0] arrival;
    logic [rrs_pkg::FIELD_W-1:0] burst;
    int jobs_in_set;
    int phase_jobs;

    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    job_ch.valid        <= 1'b0;
    job_ch.arrival_time <= '0;
    job_ch.burst_time   <= '0;
    job_ch.last_job     <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_job(directed_rows[i].arrival, directed_rows[i].burst, directed_rows[i].last,
               directed_rows[i].pinned, directed_rows[i].want);

    // zero acts as one; full range of the register; back to the reset value last
    quantum_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd3,
                     rrs_pkg::QUANT_W'($urandom_range(1, 65535)), 16'd2};
    foreach (quantum_plan[p]) begin
      write_quantum(quantum_plan[p]);
      phase_jobs = 0;
      while (phase_jobs < PHASE_JOBS) begin
        case ($urandom_range(0, 9))
          0:       jobs_in_set = $urandom_range(16, 19);  // fills the store, extras dropped
          1:       jobs_in_set = $urandom_range(7, 15);
          default: jobs_in_set = $urandom_range(1, 6);
        endcase
        for (int j = 0; j < jobs_in_set; j++) begin
          arrival = ($urandom_range(0, 3) == 0) ? rrs_pkg::FIELD_W'($urandom)
                                                : rrs_pkg::FIELD_W'($urandom_range(0, 40));
          // long bursts only where the quantum keeps the sweep count low
          if (quantum_copy >= 4096 && $urandom_range(0, 3) == 0)
            burst = rrs_pkg::FIELD_W'($urandom);
          else if ($urandom_range(0, 4) == 0)
            burst = '0;
          else
            burst = rrs_pkg::FIELD_W'($urandom_range(1, 12));
          send_job(arrival, burst, j == jobs_in_set - 1, 1'b0, '0);
        end
        phase_jobs += (jobs_in_set > JOB_SLOTS) ? JOB_SLOTS : jobs_in_set;
      end
    end

    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("round_robin_schedule_sim_unit test passed");
    else
      $display("round_robin_schedule_sim_unit test failed");
    $finish;
  end

endmodule
